>>> sv/pec10_frame_check_generate_unit_defines.svh
// Assertion macros for the PEC10 frame check/generate unit.
// Used by the checker file; expects clk and arst_n in scope.
`ifndef PEC10_FRAME_CHECK_GENERATE_UNIT_DEFINES_SVH
`define PEC10_FRAME_CHECK_GENERATE_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PEC10_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pec10 assertion failed");

// next-cycle implication, disabled in reset
`define PEC10_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pec10 assertion failed");

`endif

>>> sv/pec10_pkg.sv
// Package for the PEC10 frame check/generate unit: item types, opcodes,
// CRC constants and the bit/byte/finish update functions. No dependencies.
`default_nettype none

package pec10_pkg;

	localparam int PEC_W = 10;
	localparam int CNT_W = 6;

	localparam logic [PEC_W-1:0] PEC_POLY = 10'h08F;
	localparam logic [PEC_W-1:0] PEC_SEED = 10'd16;

	typedef enum logic [1:0] {
		OP_DATA  = 2'd0,
		OP_CHECK = 2'd1,
		OP_GEN   = 2'd2
	} pec10_op_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  data_byte;
		logic [15:0] trailer_word;
		logic [5:0]  count_to_send;
	} pec10_in_t;

	typedef struct packed {
		logic [9:0]  pec_value;
		logic [15:0] frame_trailer;
		logic        checksum_ok;
		logic [5:0]  count_received;
	} pec10_out_t;

	function automatic logic [PEC_W-1:0] pec_bit_step(input logic [PEC_W-1:0] r);
		logic [PEC_W-1:0] s;
		s = {r[PEC_W-2:0], 1'b0};
		if (r[PEC_W-1]) begin
			s = s ^ PEC_POLY;
		end
		return s;
	endfunction

	function automatic logic [PEC_W-1:0] pec_byte(input logic [PEC_W-1:0] r,
			input logic [7:0] b);
		logic [PEC_W-1:0] s;
		s = r ^ {b, 2'b00};
		for (int k = 0; k < 8; k++) begin
			s = pec_bit_step(s);
		end
		return s;
	endfunction

	function automatic logic [PEC_W-1:0] pec_finish(input logic [PEC_W-1:0] r,
			input logic [CNT_W-1:0] cnt);
		logic [PEC_W-1:0] s;
		s = r ^ {cnt, 4'b0000};
		for (int k = 0; k < CNT_W; k++) begin
			s = pec_bit_step(s);
		end
		return s;
	endfunction

endpackage

`default_nettype wire

>>> sv/pec10_in_stage.sv
// Input register stage of the PEC10 unit.
// Depends on pec10_pkg for the input item type.
`default_nettype none

module pec10_in_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              src_valid,
	input  wire pec10_pkg::pec10_in_t src_item,
	output logic                   src_stall,
	input  wire logic              advance,
	output logic                   valid_s1,
	output pec10_pkg::pec10_in_t   item_s1
);
	import pec10_pkg::*;

	assign src_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			item_s1 <= src_item;
		end
	end

endmodule

`default_nettype wire

>>> sv/pec10_crc_engine.sv
// CRC state and result computation of the PEC10 unit.
// Depends on pec10_pkg for types, opcodes and update functions.
`default_nettype none

module pec10_crc_engine (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              valid_s1,
	input  wire pec10_pkg::pec10_in_t item_s1,
	input  wire logic              slot_free,
	output logic                   advance,
	output logic                   res_load,
	output pec10_pkg::pec10_out_t  res_next
);
	import pec10_pkg::*;

	logic [PEC_W-1:0] crc_q;
	logic             is_check;
	logic             is_gen;
	logic [CNT_W-1:0] fold_cnt;
	logic [PEC_W-1:0] pec;

	assign is_check = (item_s1.opcode == OP_CHECK);
	assign is_gen   = (item_s1.opcode == OP_GEN);
	assign advance  = !(is_check || is_gen) || slot_free;
	assign res_load = valid_s1 && (is_check || is_gen) && slot_free;

	assign fold_cnt = is_check ? item_s1.trailer_word[15:10] : item_s1.count_to_send;
	assign pec      = pec_finish(crc_q, fold_cnt);

	always_comb begin
		res_next.pec_value = pec;
		if (is_check) begin
			res_next.frame_trailer  = 16'd0;
			res_next.checksum_ok    = (pec == item_s1.trailer_word[9:0]);
			res_next.count_received = item_s1.trailer_word[15:10];
		end else begin
			res_next.frame_trailer  = {item_s1.count_to_send, pec};
			res_next.checksum_ok    = 1'b0;
			res_next.count_received = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= PEC_SEED;
		end else if (valid_s1 && advance) begin
			case (item_s1.opcode)
				OP_DATA:  crc_q <= pec_byte(crc_q, item_s1.data_byte);
				OP_CHECK: crc_q <= PEC_SEED;
				OP_GEN:   crc_q <= PEC_SEED;
				default:  crc_q <= crc_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> sv/pec10_out_stage.sv
// Result register of the PEC10 unit.
// Depends on pec10_pkg for the result item type.
`default_nettype none

module pec10_out_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               res_load,
	input  wire pec10_pkg::pec10_out_t res_next,
	output logic                    slot_free,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output pec10_pkg::pec10_out_t   res_item
);
	import pec10_pkg::*;

	logic res_valid_q;

	assign slot_free = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (slot_free) begin
			res_valid_q <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_item <= res_next;
		end
	end

endmodule

`default_nettype wire

>>> sv/pec10_frame_check_generate_unit.sv
// PEC10 frame check/generate unit: takes one item per clock, data bytes fold into a
// 10-bit CRC (poly 0x8F, seed 16) and give no result; a finish item (check or generate)
// folds in the 6-bit command count, emits one result via the input and result registers
// and re-seeds the CRC. Sustained rate is one item per cycle, set by the combinational
// byte and finish update of the CRC register; input stalls only while a result waits.
// Top level; depends on pec10_pkg, pec10_in_stage, pec10_crc_engine, pec10_out_stage.
`default_nettype none

module pec10_frame_check_generate_unit (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  src_valid,
	output logic                       src_stall,
	input  wire pec10_pkg::pec10_in_t  src_item,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output pec10_pkg::pec10_out_t      res_item
);
	import pec10_pkg::*;

	logic       advance;
	logic       valid_s1;
	pec10_in_t  item_s1;
	logic       slot_free;
	logic       res_load;
	pec10_out_t res_next;

	pec10_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_item  (src_item),
		.src_stall (src_stall),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	pec10_crc_engine u_crc (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.slot_free (slot_free),
		.advance   (advance),
		.res_load  (res_load),
		.res_next  (res_next)
	);

	pec10_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_load  (res_load),
		.res_next  (res_next),
		.slot_free (slot_free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

`default_nettype wire

>>> sv/pec10_checker.sv
// Port-level checker for the PEC10 unit, bound to the top level.
// Depends on pec10_pkg and the assertion macros header.
`default_nettype none
`include "pec10_frame_check_generate_unit_defines.svh"

module pec10_checker (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  src_valid,
	input wire logic                  src_stall,
	input wire pec10_pkg::pec10_in_t  src_item,
	input wire logic                  res_valid,
	input wire logic                  res_stall,
	input wire pec10_pkg::pec10_out_t res_item
);
	import pec10_pkg::*;

	logic src_take;

	assign src_take = src_valid && !src_stall;

	`PEC10_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid)
	`PEC10_ASSERT_NEXT(a_res_stable, res_valid && res_stall, $stable(res_item))
	// generated trailer carries the PEC and no check-mode fields
	`PEC10_ASSERT_NOW(a_gen_fields, res_valid && (res_item.frame_trailer != 16'd0), (res_item.frame_trailer[9:0] == res_item.pec_value) && !res_item.checksum_ok && (res_item.count_received == 6'd0))
	// check-mode match never carries a trailer
	`PEC10_ASSERT_NOW(a_chk_fields, res_valid && res_item.checksum_ok, (res_item.frame_trailer == 16'd0) && !$isunknown(src_take))

endmodule

bind pec10_frame_check_generate_unit pec10_checker u_chk (.*);

`default_nettype wire
